>>> rtl/two_point_gain_offset_correction_defines.svh
// Assertion macros shared by the checker of the gain/offset correction block.
// Depends on nothing; included by the checker file only.
`ifndef TWO_POINT_GAIN_OFFSET_CORRECTION_DEFINES_SVH
`define TWO_POINT_GAIN_OFFSET_CORRECTION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gpc_pkg.sv
// Package of the two-point gain/offset correction block: constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps

package gpc_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int WORD_W            = 16;
    localparam int STATUS_W          = 2;
    localparam int CFG_INDEX_W       = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_MEAS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_EXP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_MEAS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_EXP  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP_LO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMP_HI = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

    // calibration unit status toward the datapath
    typedef struct packed {
        logic ready;
        logic invalid;
        logic gain_neg;
    } cal_stat_t;

endpackage

>>> rtl/gpc_if.sv
// Handshake channel interfaces (valid/ready plus payload) for input and result words.
// Depends on gpc_pkg.
`timescale 1ns / 1ps

interface gpc_in_if;
    logic                         valid;
    logic                         ready;
    logic [gpc_pkg::WORD_W-1:0]   raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface gpc_out_if;
    logic                         valid;
    logic                         ready;
    logic [gpc_pkg::WORD_W-1:0]   corrected_sample;
    logic [gpc_pkg::STATUS_W-1:0] correction_status;

    modport source (output valid, output corrected_sample, output correction_status,
                    input ready);
    modport sink   (input valid, input corrected_sample, input correction_status,
                    output ready);
endinterface

>>> rtl/gpc_cal.sv
// Calibration unit: derives gain (bit-serial rounded divide) and offset from the
// four calibration registers. Depends on gpc_pkg.
`timescale 1ns / 1ps

module gpc_cal #(
    parameter int FRACTION_BITS = gpc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [gpc_pkg::WORD_W-1:0]        low_meas,
    input  logic [gpc_pkg::WORD_W-1:0]        low_exp,
    input  logic [gpc_pkg::WORD_W-1:0]        high_meas,
    input  logic [gpc_pkg::WORD_W-1:0]        high_exp,
    output gpc_pkg::cal_stat_t                stat,
    output logic [16+FRACTION_BITS-1:0]       gain_mag,
    output logic [34+FRACTION_BITS-1:0]       offset
);

    localparam int AW = 16 + FRACTION_BITS;
    localparam int QW = 17 + FRACTION_BITS;
    localparam int OW = 34 + FRACTION_BITS;
    localparam int PW = AW + 16;
    localparam int CW = $clog2(QW + 1);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } cal_state_t;

    cal_state_t       state_reg, state_next;
    logic [QW-1:0]    quot_reg, quot_next;
    logic [15:0]      rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             inv_reg, inv_next;
    logic             neg_reg, neg_next;
    logic [OW-1:0]    off_reg, off_next;

    logic signed [16:0] num, den;
    logic [15:0]        anum, aden;
    logic [16:0]        rs;
    logic               ge;
    logic [PW-1:0]      prod;
    logic [OW-1:0]      le_sh;

    // spans of the two calibration points
    assign num  = $signed({1'b0, high_exp}) - $signed({1'b0, low_exp});
    assign den  = $signed({1'b0, high_meas}) - $signed({1'b0, low_meas});
    assign anum = num[16] ? 16'(-num) : num[15:0];
    assign aden = den[16] ? 16'(-den) : den[15:0];

    // one restoring divide step
    assign rs = {rem_reg, quot_reg[QW-1]};
    assign ge = rs >= {1'b0, aden};

    // offset terms
    assign prod  = PW'(quot_reg[AW-1:0]) * PW'(low_meas);
    assign le_sh = OW'(low_exp) << FRACTION_BITS;

    always_comb
    begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        inv_next   = inv_reg;
        neg_next   = neg_reg;
        off_next   = off_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                inv_next  = (den == 17'sd0);
                neg_next  = num[16] ^ den[16];
                quot_next = (QW'(anum) << FRACTION_BITS) + QW'(aden >> 1);
                rem_next  = '0;
                cnt_next  = '0;
                state_next = (den == 17'sd0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? 16'(rs - {1'b0, aden}) : rs[15:0];
                quot_next = {quot_reg[QW-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // offset = gain * low_meas - low_exp, in gain format
                off_next = (neg_reg ? -OW'(prod) : OW'(prod)) - le_sh;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (start)
        begin
            state_next = S_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            inv_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inv_reg   <= inv_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        off_reg  <= off_next;
    end

    assign stat.ready    = (state_reg == S_DONE);
    assign stat.invalid  = inv_reg;
    assign stat.gain_neg = neg_reg;
    assign gain_mag      = quot_reg[AW-1:0];
    assign offset        = off_reg;

endmodule

>>> rtl/two_point_gain_offset_correction.sv
// Channel    | dir | payload
// in_ch      | in  | raw_sample[15:0]
// out_ch     | out | corrected_sample[15:0], correction_status[1:0]
// cfg_wr_en / cfg_index / cfg_data | in | calibration register write
//
// One word per cycle while out_ch is not stalled and calibration is done; a word
// passes four register stages: difference, partial products, rounded sum, clamp.
// After reset and after every register write the gain divider runs, one quotient bit
// a cycle, unless the measured points are equal; in_ch.ready stays low until it is done.
// A stall on out_ch freezes all stages together; nothing is dropped or repeated.
// Top level; depends on gpc_pkg, gpc_if, gpc_cal.
`timescale 1ns / 1ps

module two_point_gain_offset_correction #(
    parameter int FRACTION_BITS = gpc_pkg::FRACTION_BITS_DEF,
    parameter int SAMPLE_BITS   = gpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gpc_in_if.sink                              in_ch,
    gpc_out_if.source                           out_ch,
    input  logic                                cfg_wr_en,
    input  logic [gpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gpc_pkg::WORD_W-1:0]          cfg_data
);

    localparam int AW  = 16 + FRACTION_BITS;
    localparam int OW  = 34 + FRACTION_BITS;
    localparam int DW  = OW + 1;
    localparam int MW  = OW;
    localparam int AL  = AW / 2;
    localparam int AH  = AW - AL;
    localparam int ML  = MW / 2;
    localparam int MH  = MW - ML;
    localparam int PW  = MW + AW;
    localparam int SW  = PW + 1;
    localparam int RSH = 2 * FRACTION_BITS;
    localparam int RW  = SW - RSH;

    // calibration registers
    logic [gpc_pkg::WORD_W-1:0] low_meas_reg, low_exp_reg, high_meas_reg, high_exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_meas_reg  <= '0;
            low_exp_reg   <= '0;
            high_meas_reg <= '1;
            high_exp_reg  <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gpc_pkg::REG_LOW_MEAS:  low_meas_reg  <= cfg_data;
                gpc_pkg::REG_LOW_EXP:   low_exp_reg   <= cfg_data;
                gpc_pkg::REG_HIGH_MEAS: high_meas_reg <= cfg_data;
                gpc_pkg::REG_HIGH_EXP:  high_exp_reg  <= cfg_data;
                default:                low_meas_reg  <= low_meas_reg;
            endcase
        end
    end

    gpc_pkg::cal_stat_t cal;
    logic [AW-1:0]      gain_mag;
    logic [OW-1:0]      offset;

    gpc_cal #(.FRACTION_BITS(FRACTION_BITS)) u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_wr_en),
        .low_meas  (low_meas_reg),
        .low_exp   (low_exp_reg),
        .high_meas (high_meas_reg),
        .high_exp  (high_exp_reg),
        .stat      (cal),
        .gain_mag  (gain_mag),
        .offset    (offset)
    );

    // pipeline advance: output empty or being taken
    logic adv, in_acc;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv         = !v4_reg || out_ch.ready;
    assign in_ch.ready = adv && cal.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: d = sample - offset, split into sign and magnitude
    logic [DW-1:0] s_ext, d;
    logic [MW-1:0] mag1_reg;
    logic          neg1_reg, neg2_reg, neg3_reg;

    assign s_ext = DW'(in_ch.raw_sample[SAMPLE_BITS-1:0]) << FRACTION_BITS;
    assign d     = s_ext - {offset[OW-1], offset};

    // stage 2: four partial products
    logic [ML+AL-1:0] p_ll_reg;
    logic [ML+AH-1:0] p_lh_reg;
    logic [MH+AL-1:0] p_hl_reg;
    logic [MH+AH-1:0] p_hh_reg;

    // stage 3: rounded sum
    logic [SW-1:0] sum_reg, sum_next;
    logic [RW-1:0] res;

    assign sum_next = (SW'(p_hh_reg) << (ML + AL)) + (SW'(p_hl_reg) << ML)
                    + (SW'(p_lh_reg) << AL) + SW'(p_ll_reg) + (SW'(1'b1) << (RSH - 1));
    assign res = sum_reg[SW-1:RSH];

    // stage 4: clamp and status
    logic [gpc_pkg::WORD_W-1:0]   corr_reg, corr_next;
    logic [gpc_pkg::STATUS_W-1:0] stat_reg, stat_next;

    always_comb
    begin
        priority if (cal.invalid)
        begin
            corr_next = '0;
            stat_next = gpc_pkg::ST_INVALID;
        end
        else if (res == '0)
        begin
            corr_next = '0;
            stat_next = gpc_pkg::ST_OK;
        end
        else if (neg3_reg)
        begin
            corr_next = '0;
            stat_next = gpc_pkg::ST_CLAMP_LO;
        end
        else if (|(res >> SAMPLE_BITS))
        begin
            corr_next = gpc_pkg::WORD_W'({SAMPLE_BITS{1'b1}});
            stat_next = gpc_pkg::ST_CLAMP_HI;
        end
        else
        begin
            corr_next = gpc_pkg::WORD_W'(res[SAMPLE_BITS-1:0]);
            stat_next = gpc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= d[DW-1] ? MW'(-d) : d[MW-1:0];
            neg1_reg <= d[DW-1] ^ cal.gain_neg;
            p_ll_reg <= (ML+AL)'(mag1_reg[ML-1:0]) * (ML+AL)'(gain_mag[AL-1:0]);
            p_lh_reg <= (ML+AH)'(mag1_reg[ML-1:0]) * (ML+AH)'(gain_mag[AW-1:AL]);
            p_hl_reg <= (MH+AL)'(mag1_reg[MW-1:ML]) * (MH+AL)'(gain_mag[AL-1:0]);
            p_hh_reg <= (MH+AH)'(mag1_reg[MW-1:ML]) * (MH+AH)'(gain_mag[AW-1:AL]);
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            neg3_reg <= neg2_reg;
            corr_reg <= corr_next;
            stat_reg <= stat_next;
        end
    end

    assign out_ch.valid             = v4_reg;
    assign out_ch.corrected_sample  = corr_reg;
    assign out_ch.correction_status = stat_reg;

endmodule

>>> rtl/gpc_checker.sv
// Port-level checker for the two-point gain/offset correction block, bound to the top.
// Depends on gpc_pkg and two_point_gain_offset_correction_defines.svh.
`timescale 1ns / 1ps
`include "two_point_gain_offset_correction_defines.svh"

module gpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [gpc_pkg::WORD_W-1:0]     corrected_sample,
    input logic [gpc_pkg::STATUS_W-1:0]   correction_status
);

    logic stalled, zero_forced;
    logic [gpc_pkg::WORD_W+gpc_pkg::STATUS_W-1:0] out_word;

    assign stalled     = out_valid && !out_ready;
    assign zero_forced = out_valid && (correction_status == gpc_pkg::ST_INVALID ||
                                       correction_status == gpc_pkg::ST_CLAMP_LO);
    assign out_word    = {corrected_sample, correction_status};

    // a waiting result stays until taken
    `GPC_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid, "result dropped while stalled")

    // a waiting result keeps its payload
    `GPC_ASSERT_NEXT(a_word_hold, clk, rst_n, stalled, $stable(out_word), "word changed in stall")

    // full and stalled output blocks intake
    `GPC_ASSERT_SAME(a_stall_in, clk, rst_n, stalled, !in_ready, "input taken during output stall")

    // invalid calibration and low clamp give zero
    `GPC_ASSERT_SAME(a_inv_zero, clk, rst_n, zero_forced, corrected_sample == '0, "nonzero clamp")

endmodule

bind two_point_gain_offset_correction gpc_checker u_gpc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .corrected_sample  (out_ch.corrected_sample),
    .correction_status (out_ch.correction_status)
);

>>> tb/two_point_gain_offset_correction_tb.sv
// Testbench for the two-point gain/offset correction block: directed and random
// samples under several calibrations, checked against an in-bench predictor.
// Depends on gpc_pkg, gpc_if and the block's RTL.
`timescale 1ns / 1ps

module two_point_gain_offset_correction_tb;

    typedef struct packed {
        logic [gpc_pkg::WORD_W-1:0]   sample;
        logic [gpc_pkg::STATUS_W-1:0] status;
    } corr_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [gpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gpc_pkg::WORD_W-1:0] cfg_data = '0;

    gpc_in_if  in_ch ();
    gpc_out_if out_ch ();

    // calibration copy held by the predictor
    logic [15:0] cal_lo_meas, cal_lo_exp, cal_hi_meas, cal_hi_exp;

    corr_word_t corrections_due[$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned calibrations = 0;
    int unsigned clamp_seen[4] = '{0, 0, 0, 0};
    int out_gap = 0;

    always #2 clk = ~clk;

    two_point_gain_offset_correction u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // expected corrected word for one raw sample under the current calibration
    function automatic corr_word_t correct_sample(logic [15:0] raw);
        corr_word_t r;
        longint num, den, g, off, d, mag, q;
        longint unsigned anum, aden, ag;
        logic [127:0] prod;
        logic neg;
        num = longint'(cal_hi_exp) - longint'(cal_lo_exp);
        den = longint'(cal_hi_meas) - longint'(cal_lo_meas);
        if (den == 0)
        begin
            r.sample = '0;
            r.status = gpc_pkg::ST_INVALID;
            return r;
        end
        anum = (num < 0) ? -num : num;
        aden = (den < 0) ? -den : den;
        ag = ((anum << 16) + aden / 2) / aden;
        g = ((num < 0) != (den < 0)) ? -longint'(ag) : longint'(ag);
        off = g * longint'(cal_lo_meas) - (longint'(cal_lo_exp) << 16);
        d = (longint'(raw) << 16) - off;
        neg = (d < 0) != (g < 0);
        mag = (d < 0) ? -d : d;
        prod = 128'(mag) * 128'(ag) + (128'd1 << 31);
        prod = prod >> 32;
        if (prod == 0)
        begin
            r.sample = '0;
            r.status = gpc_pkg::ST_OK;
        end
        else if (neg)
        begin
            r.sample = '0;
            r.status = gpc_pkg::ST_CLAMP_LO;
        end
        else if (prod > 128'd65535)
        begin
            r.sample = 16'hFFFF;
            r.status = gpc_pkg::ST_CLAMP_HI;
        end
        else
        begin
            q = longint'(prod[63:0]);
            r.sample = q[15:0];
            r.status = gpc_pkg::ST_OK;
        end
        return r;
    endfunction

    // send one raw word after a random gap
    task automatic send_sample(logic [15:0] raw);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_sample <= raw;
        corrections_due.push_back(correct_sample(raw));
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic wait_drained();
        release_input();
        while (corrections_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [gpc_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gpc_pkg::REG_LOW_MEAS:  cal_lo_meas = val;
            gpc_pkg::REG_LOW_EXP:   cal_lo_exp = val;
            gpc_pkg::REG_HIGH_MEAS: cal_hi_meas = val;
            default:                cal_hi_exp = val;
        endcase
    endtask

    task automatic calibrate(logic [15:0] lm, logic [15:0] le, logic [15:0] hm,
                             logic [15:0] he);
        wait_drained();
        write_reg(gpc_pkg::REG_LOW_MEAS, lm);
        write_reg(gpc_pkg::REG_LOW_EXP, le);
        write_reg(gpc_pkg::REG_HIGH_MEAS, hm);
        write_reg(gpc_pkg::REG_HIGH_EXP, he);
        calibrations++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return cal_lo_meas + 16'($urandom_range(0, 3)) - 16'd1;
            3: return cal_hi_meas + 16'($urandom_range(0, 3)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker; the output side holds ready low for a random gap before each word
    always @(posedge clk)
    begin
        corr_word_t exp_w;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_gap = $urandom_range(0, 4);
                if (corrections_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: sample %0d status %0d",
                                 out_ch.corrected_sample, out_ch.correction_status);
                end
                else
                begin
                    exp_w = corrections_due.pop_front();
                    words_checked++;
                    clamp_seen[exp_w.status]++;
                    if (out_ch.corrected_sample !== exp_w.sample ||
                        out_ch.correction_status !== exp_w.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d got %0d/%0d (cal %0d %0d %0d %0d)",
                                     exp_w.sample, exp_w.status, out_ch.corrected_sample,
                                     out_ch.correction_status, cal_lo_meas, cal_lo_exp,
                                     cal_hi_meas, cal_hi_exp);
                    end
                end
            end
        end
        if (out_gap != 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap--;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // identity calibration from reset, extremes of the sample
    task automatic test_reset_identity();
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFE);
        send_sample(16'hFFFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
    endtask

    // special calibrations: clamps, negative gain, invalid, wide range
    task automatic test_directed_cals();
        calibrate(16'd1000, 16'd0, 16'd60000, 16'd65535);
        send_sample(16'd0);
        send_sample(16'd1000);
        send_sample(16'd65535);
        calibrate(16'd0, 16'd65535, 16'd65535, 16'd0);
        send_sample(16'd0);
        send_sample(16'd65535);
        send_sample(16'd32768);
        calibrate(16'd500, 16'd7, 16'd500, 16'd9000);
        send_sample(16'd500);
        send_sample(16'd3);
        calibrate(16'd65535, 16'd65535, 16'd0, 16'd0);
        send_sample(16'd1);
        send_sample(16'd65534);
        calibrate(16'd100, 16'd0, 16'd101, 16'd65535);
        send_sample(16'd99);
        send_sample(16'd100);
        send_sample(16'd102);
    endtask

    // random calibrations, each followed by a burst of random samples
    task automatic test_random_cals();
        int n, len;
        for (n = 0; n < 40; n++)
        begin
            calibrate(16'($urandom), 16'($urandom),
                      ($urandom_range(0, 9) == 0) ? cal_lo_meas : 16'($urandom),
                      16'($urandom));
            if ($urandom_range(0, 9) == 0)
                calibrate(cal_lo_meas, cal_lo_exp, cal_lo_meas, cal_hi_exp);
            len = $urandom_range(25, 60);
            repeat (len) send_sample(pick_sample());
        end
    endtask

    initial
    begin
        in_ch.valid <= 1'b0;
        in_ch.raw_sample <= '0;
        cal_lo_meas = 16'd0;
        cal_lo_exp = 16'd0;
        cal_hi_meas = 16'hFFFF;
        cal_hi_exp = 16'hFFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_identity();
        test_directed_cals();
        test_random_cals();
        wait_drained();
        $display("%0d words sent, %0d checked over %0d calibrations",
                 words_sent, words_checked, calibrations);
        $display("status counts ok %0d low %0d high %0d invalid %0d",
                 clamp_seen[0], clamp_seen[1], clamp_seen[2], clamp_seen[3]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("timeout with %0d words outstanding", corrections_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/gpc_pkg.sv
rtl/gpc_if.sv
rtl/gpc_cal.sv
rtl/two_point_gain_offset_correction.sv
rtl/gpc_checker.sv
tb/two_point_gain_offset_correction_tb.sv
